// ----- rtl/orp_pkg.sv -----
// Package for the OOK packet receiver with majority voting.
// Holds the item and configuration types, the sizes and the slot and register codes.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package orp_pkg;

	// Number of packets gathered before an evaluation.
	localparam int REPEATS = 3;
	// Data bits carried by one packet (at most eight).
	localparam int DATA_BITS = 8;
	// Width of the signed, saturating vote accumulator.
	localparam int VOTE_WIDTH = 16;

	localparam int PKT_IDX_W = (REPEATS > 1) ? $clog2(REPEATS) : 1;

	// Slot codes of the packet frame.
	localparam logic [4:0] SLOT_SYNC_ONE = 5'd0;
	localparam logic [4:0] SLOT_SYNC_ZERO = 5'd1;
	localparam logic [4:0] SLOT_CHAN_LAST = 5'd5;
	localparam logic [4:0] SLOT_DATA_LAST = 5'(DATA_BITS + 5);
	localparam logic [4:0] SLOT_MAX = 5'd31;

	localparam logic [2:0] PKT_COUNT_FULL = 3'(REPEATS);
	localparam logic [7:0] SINCE_MAX = 8'd255;

	// Register indexes of the configuration port.
	localparam logic [1:0] CFG_PULSE_TICKS = 2'd0;
	localparam logic [1:0] CFG_CHANNEL_ID = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

	localparam logic [4:0] PULSE_TICKS_RESET = 5'd10;
	localparam logic [3:0] CHANNEL_ID_RESET = 4'd3;
	localparam logic [7:0] TIMEOUT_TICKS_RESET = 8'd255;

	typedef struct packed {
		logic line_level;
		logic tick;
	} in_item_t;

	typedef struct packed {
		logic [7:0] decoded_value;
		logic       value_valid;
		logic       red_on;
		logic       blue_on;
		logic       green_on;
		logic       receiving;
	} out_item_t;

	typedef struct packed {
		logic [4:0] pulse_ticks;
		logic [3:0] channel_id;
		logic [7:0] timeout_ticks;
	} cfg_t;

	typedef logic [REPEATS-1:0][7:0] pkt_store_t;

endpackage

`default_nettype wire

// ----- rtl/orp_agree.sv -----
// Packet agreement check for the OOK packet receiver.
// Finds the lowest stored packet that equals another compared packet.
// Depends on orp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module orp_agree (
	input  orp_pkg::pkt_store_t store,
	input  logic [2:0]          count,
	output logic                found,
	output logic [7:0]          value
);
	import orp_pkg::*;

	logic [2:0]         last;
	logic [REPEATS-1:0] match;

	// Only packets up to the current count take part, capped at the last slot.
	assign last = (count > 3'(REPEATS - 1)) ? 3'(REPEATS - 1) : count;

	always_comb begin
		match = '0;
		for (int i = 0; i < REPEATS; i++) begin
			for (int l = 0; l < REPEATS; l++) begin
				if (i != l && 3'(i) <= last && 3'(l) <= last && store[i] == store[l]) begin
					match[i] = 1'b1;
				end
			end
		end
	end

	always_comb begin
		found = 1'b0;
		value = '0;
		for (int i = REPEATS - 1; i >= 0; i--) begin
			if (match[i]) begin
				found = 1'b1;
				value = store[i];
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/orp_core.sv -----
// Receiver state and per-sample decode logic of the OOK packet receiver.
// Sync hunting, slot timing, voting, framing, packet storage and evaluation.
// Depends on orp_pkg and orp_agree.
`timescale 1ns / 1ps
`default_nettype none

module orp_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  orp_pkg::in_item_t  sample,
	input  orp_pkg::cfg_t      cfg,
	output orp_pkg::out_item_t result
);
	import orp_pkg::*;

	localparam logic [VOTE_WIDTH-1:0] VOTE_MAX = {1'b0, {(VOTE_WIDTH - 1){1'b1}}};
	localparam logic [VOTE_WIDTH-1:0] VOTE_MIN = {1'b1, {(VOTE_WIDTH - 1){1'b0}}};
	localparam logic [VOTE_WIDTH-1:0] VOTE_ONE = {{(VOTE_WIDTH - 1){1'b0}}, 1'b1};

	logic                  synced_q, prev_q;
	logic [7:0]            tick_q, since_q, agreed_q;
	logic [4:0]            slot_q, decided_q;
	logic [VOTE_WIDTH-1:0] vote_q;
	logic [3:0]            chan_q;
	logic [2:0]            pc_q, lamp_q;
	pkt_store_t            store_q;

	logic                  a_synced, a_eval;
	logic [7:0]            a_tick, a_since;
	logic [4:0]            a_slot, a_decided;
	logic [VOTE_WIDTH-1:0] a_vote;
	logic [3:0]            a_chan;
	logic [2:0]            a_pc;
	pkt_store_t            a_store;

	logic                  n_synced;
	logic [7:0]            n_tick, n_since, n_agreed;
	logic [4:0]            n_slot, n_decided;
	logic [VOTE_WIDTH-1:0] n_vote;
	logic [3:0]            n_chan;
	logic [2:0]            n_pc, n_lamp;
	pkt_store_t            n_store;

	logic                  ev_found;
	logic [7:0]            ev_value;

	// First part: edge, tick and vote handling up to the point of evaluation.
	always_comb begin
		logic [5:0]  slot_up;
		logic [10:0] bound;
		logic        bitval;
		logic        restart;

		a_synced = synced_q;
		a_tick = tick_q;
		a_since = since_q;
		a_slot = slot_q;
		a_decided = decided_q;
		a_vote = vote_q;
		a_chan = chan_q;
		a_pc = pc_q;
		a_store = store_q;
		a_eval = 1'b0;
		restart = 1'b0;
		bitval = 1'b0;
		slot_up = {1'b0, slot_q} + 6'd1;
		bound = {5'b0, slot_up} * {6'b0, cfg.pulse_ticks};

		// While hunting, each edge restarts the low timer; a rising edge after
		// a low of one pulse length, give or take one tick, locks on.
		if (!synced_q && sample.line_level != prev_q) begin
			if (sample.line_level &&
			    ({1'b0, tick_q} + 9'd1) >= {4'b0, cfg.pulse_ticks} &&
			    {1'b0, tick_q} <= ({4'b0, cfg.pulse_ticks} + 9'd1)) begin
				a_synced = 1'b1;
			end
			a_tick = '0;
		end

		if (sample.tick) begin
			a_tick = a_tick + 8'd1;
			if (since_q >= cfg.timeout_ticks) begin
				a_eval = 1'b1;
			end else if (a_synced) begin
				if (since_q != SINCE_MAX) begin
					a_since = since_q + 8'd1;
				end
				if ({3'b0, a_tick} == bound && slot_q != SLOT_MAX) begin
					a_slot = slot_up[4:0];
				end
			end
		end

		if (a_synced && !a_eval) begin
			if (sample.line_level) begin
				if (vote_q != VOTE_MAX) begin
					a_vote = vote_q + VOTE_ONE;
				end
			end else begin
				if (vote_q != VOTE_MIN) begin
					a_vote = vote_q - VOTE_ONE;
				end
			end
			// The sample that shows a new slot still counts for the old one.
			if (decided_q != a_slot) begin
				bitval = !a_vote[VOTE_WIDTH-1] && (a_vote != '0);
				a_vote = '0;
				if (decided_q == SLOT_SYNC_ONE) begin
					restart = !bitval;
				end else if (decided_q == SLOT_SYNC_ZERO) begin
					restart = bitval;
				end else if (decided_q <= SLOT_CHAN_LAST) begin
					a_chan = {chan_q[2:0], bitval};
				end else if (chan_q != cfg.channel_id) begin
					restart = 1'b1;
				end else begin
					a_since = '0;
					if (pc_q < PKT_COUNT_FULL) begin
						a_store[pc_q[PKT_IDX_W-1:0]] =
							{store_q[pc_q[PKT_IDX_W-1:0]][6:0], bitval};
					end
				end
				if (!restart) begin
					if (decided_q >= SLOT_DATA_LAST) begin
						a_pc = pc_q + 3'd1;
						if (a_pc == PKT_COUNT_FULL) begin
							a_eval = 1'b1;
						end
						restart = 1'b1;
					end else begin
						a_decided = a_slot;
					end
				end
			end
		end

		if (restart) begin
			a_synced = 1'b0;
			a_slot = '0;
			a_tick = '0;
			a_decided = '0;
			a_chan = '0;
			a_vote = '0;
		end
	end

	orp_agree u_agree (
		.store (a_store),
		.count (a_pc),
		.found (ev_found),
		.value (ev_value)
	);

	// Second part: an evaluation takes the agreed value, sets the lamps and
	// clears the packets and the receive state.
	always_comb begin
		n_synced = a_synced;
		n_tick = a_tick;
		n_since = a_since;
		n_slot = a_slot;
		n_decided = a_decided;
		n_vote = a_vote;
		n_chan = a_chan;
		n_pc = a_pc;
		n_store = a_store;
		n_agreed = agreed_q;
		n_lamp = lamp_q;
		if (a_eval) begin
			if (ev_found) begin
				n_agreed = ev_value;
			end
			n_lamp = {n_agreed == 8'd2, n_agreed == 8'd1, n_agreed == 8'd0};
			n_store = '0;
			n_pc = '0;
			n_since = '0;
			n_synced = 1'b0;
			n_slot = '0;
			n_tick = '0;
			n_decided = '0;
			n_chan = '0;
			n_vote = '0;
		end
	end

	always_comb begin
		result.decoded_value = n_agreed;
		result.value_valid = a_eval;
		result.red_on = n_lamp[0];
		result.blue_on = n_lamp[1];
		result.green_on = n_lamp[2];
		result.receiving = n_synced;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			synced_q <= 1'b0;
			prev_q <= 1'b0;
			tick_q <= '0;
			since_q <= '0;
			slot_q <= '0;
			decided_q <= '0;
			vote_q <= '0;
			chan_q <= '0;
			pc_q <= '0;
			store_q <= '0;
			agreed_q <= '0;
			lamp_q <= '0;
		end else if (advance) begin
			synced_q <= n_synced;
			prev_q <= sample.line_level;
			tick_q <= n_tick;
			since_q <= n_since;
			slot_q <= n_slot;
			decided_q <= n_decided;
			vote_q <= n_vote;
			chan_q <= n_chan;
			pc_q <= n_pc;
			store_q <= n_store;
			agreed_q <= n_agreed;
			lamp_q <= n_lamp;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ook_packet_receiver_voting.sv -----
// Top level of the OOK packet receiver with majority voting.
// Input register, configuration registers, result register; decode in orp_core.
// Depends on orp_pkg, orp_core and orp_agree.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Handshake                  Payload            Carries
//  -------   ------------------------   ----------------   ------------------------------
//  sample    sample_valid/sample_stall  sample             one line sample and tick flag
//  result    result_valid/result_stall  result             agreed value, lamps, status
//  config    cfg_write                  cfg_index/cfg_data pulse, channel, timeout regs
//
// The block takes one item per clock while sample_stall is low and returns one result
// item for each. Each item passes an input register and then the result register,
// from which its result item is offered; the decode of one sample is a single pass of
// logic between those two registers, and the slot boundary needs one small multiply
// of slot number by pulse length.
// Reset clears all receive state, the packet store and the lamps, and loads the
// registers with pulse length 10, channel 3 and timeout 255.
// While the result register holds an item that is stalled, the input register
// holds its item and sample_stall rises; a free result register never stalls input.

module ook_packet_receiver_voting (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  orp_pkg::in_item_t  sample,
	output logic               result_valid,
	input  logic               result_stall,
	output orp_pkg::out_item_t result,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);
	import orp_pkg::*;

	logic      valid_s1;
	in_item_t  sample_s1;
	logic      result_valid_q;
	out_item_t result_q;
	out_item_t next_result;
	cfg_t      cfg_q;
	logic      advance;

	// The item in the input register moves on whenever the result register is
	// empty or its item is being taken in this cycle.
	assign advance = valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	// The user must write configuration only with no item in flight; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_ticks <= PULSE_TICKS_RESET;
			cfg_q.channel_id <= CHANNEL_ID_RESET;
			cfg_q.timeout_ticks <= TIMEOUT_TICKS_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_PULSE_TICKS: begin
					cfg_q.pulse_ticks <= cfg_data[4:0];
				end
				CFG_CHANNEL_ID: begin
					cfg_q.channel_id <= cfg_data[3:0];
				end
				CFG_TIMEOUT_TICKS: begin
					cfg_q.timeout_ticks <= cfg_data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	orp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.sample  (sample_s1),
		.cfg     (cfg_q),
		.result  (next_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= next_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ----- tb/sv/ook_packet_receiver_voting_test.sv -----
// Testbench of ook_packet_receiver_voting: radio frames, faults, timeouts and random traffic.
// Results are checked item by item against a bit-exact predictor of the decoder.
// Depends on orp_pkg and the block's RTL only.
`timescale 1ns / 1ps

module ook_packet_receiver_voting_test;

	import orp_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_ITEMS = 150;
	localparam int VOTE_MAX = (1 << (VOTE_WIDTH - 1)) - 1;
	localparam int VOTE_MIN = -VOTE_MAX - 1;
	// Slot 0 high and slot 1 low is the only sync pattern the decoder accepts.
	localparam logic [1:0] SYNC_GOOD = 2'b10;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               sample_valid = 1'b0;
	logic               sample_stall;
	in_item_t           sample = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	out_item_t          result;
	logic               cfg_write = 1'b0;
	logic [1:0]         cfg_index = CFG_PULSE_TICKS;
	logic [7:0]         cfg_data = '0;

	ook_packet_receiver_voting i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	// Decoder state as the predictor sees it, plus its copy of the registers.
	logic [4:0] cfg_pulse;
	logic [3:0] cfg_chan;
	logic [7:0] cfg_timeout;
	logic       rx_synced;
	logic       rx_prev_level;
	logic [7:0] rx_tick_count;
	logic [7:0] rx_since_data;
	int         rx_slot;
	int         rx_decided;
	int         rx_vote;
	logic [3:0] rx_chan;
	logic [2:0] rx_pkt_count;
	logic [7:0] rx_store [REPEATS];
	logic [7:0] rx_agreed;
	logic       rx_red;
	logic       rx_blue;
	logic       rx_green;

	// Decoded items still owed by the block, oldest first.
	out_item_t  pending_decodes [$];
	out_item_t  oldest_decode;
	int         samples_sent = 0;
	int         fail_count = 0;
	int         cycle_count = 0;

	// Sender bursts and receiver stall runs.
	bit         sender_gaps = 1'b1;
	int         burst_left = 0;
	bit         stall_enable = 1'b1;
	bit         stall_now = 1'b0;
	int         stall_left = 0;

	// ---------------------------------------------------------------- predictor

	function automatic void rx_restart();
		rx_synced = 1'b0;
		rx_slot = 0;
		rx_tick_count = '0;
		rx_decided = 0;
		rx_chan = '0;
		rx_vote = 0;
	endfunction

	function automatic void rx_reset_state();
		cfg_pulse = PULSE_TICKS_RESET;
		cfg_chan = CHANNEL_ID_RESET;
		cfg_timeout = TIMEOUT_TICKS_RESET;
		rx_prev_level = 1'b0;
		rx_since_data = '0;
		rx_pkt_count = '0;
		rx_agreed = '0;
		{rx_red, rx_blue, rx_green} = '0;
		for (int i = 0; i < REPEATS; i++)
			rx_store[i] = '0;
		rx_restart();
	endfunction

	// Compares the packets gathered so far. The lowest index that has a twin wins;
	// with no pair at all the previous agreed value stays.
	function automatic void evaluate_packets();
		int last_idx;
		last_idx = (rx_pkt_count > REPEATS - 1) ? REPEATS - 1 : int'(rx_pkt_count);
		for (int i = last_idx; i >= 0; i--)
			for (int j = last_idx; j >= 0; j--)
				if (i != j && rx_store[i] == rx_store[j])
					rx_agreed = rx_store[i];
		for (int i = 0; i < REPEATS; i++)
			rx_store[i] = '0;
		rx_red = (rx_agreed == 8'd0);
		rx_blue = (rx_agreed == 8'd1);
		rx_green = (rx_agreed == 8'd2);
		rx_pkt_count = '0;
		rx_since_data = '0;
		rx_restart();
	endfunction

	// Takes the bit of the slot just closed. Returns 0 when reception restarted.
	function automatic logic accept_slot_bit(input logic bitv, inout logic evaluated);
		if (rx_decided == SLOT_SYNC_ONE) begin
			if (bitv != 1'b1) begin
				rx_restart();
				return 1'b0;
			end
		end else if (rx_decided == SLOT_SYNC_ZERO) begin
			if (bitv != 1'b0) begin
				rx_restart();
				return 1'b0;
			end
		end else if (rx_decided <= SLOT_CHAN_LAST) begin
			rx_chan = {rx_chan[2:0], bitv};
		end else begin
			if (rx_chan != cfg_chan) begin
				rx_restart();
				return 1'b0;
			end
			rx_since_data = '0;
			if (rx_pkt_count < REPEATS)
				rx_store[rx_pkt_count] = {rx_store[rx_pkt_count][6:0], bitv};
		end
		if (rx_decided >= SLOT_DATA_LAST) begin
			rx_pkt_count = rx_pkt_count + 3'd1;
			if (rx_pkt_count == PKT_COUNT_FULL) begin
				evaluate_packets();
				evaluated = 1'b1;
			end
			rx_restart();
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// One line sample through the decoder: edges first, then the tick, then the vote.
	function automatic out_item_t decode_sample(input in_item_t s);
		out_item_t r;
		logic      evaluated;
		logic      bitv;
		int        p;
		evaluated = 1'b0;
		p = int'(cfg_pulse);
		if (!rx_synced && s.line_level != rx_prev_level) begin
			if (s.line_level && int'(rx_tick_count) >= p - 1 && int'(rx_tick_count) <= p + 1)
				rx_synced = 1'b1;
			rx_tick_count = '0;
		end
		rx_prev_level = s.line_level;
		if (s.tick) begin
			rx_tick_count = rx_tick_count + 8'd1;
			if (rx_since_data >= cfg_timeout) begin
				evaluate_packets();
				evaluated = 1'b1;
			end
			if (rx_synced) begin
				if (rx_since_data != SINCE_MAX)
					rx_since_data = rx_since_data + 8'd1;
				if (int'(rx_tick_count) == (rx_slot + 1) * p && rx_slot < int'(SLOT_MAX))
					rx_slot++;
			end
		end
		if (rx_synced) begin
			if (s.line_level) begin
				if (rx_vote < VOTE_MAX)
					rx_vote++;
			end else if (rx_vote > VOTE_MIN) begin
				rx_vote--;
			end
			// The sample that moves the slot boundary still votes for the old slot.
			if (rx_decided != rx_slot) begin
				bitv = (rx_vote > 0);
				rx_vote = 0;
				if (accept_slot_bit(bitv, evaluated))
					rx_decided = rx_slot;
			end
		end
		r.decoded_value = rx_agreed;
		r.value_valid = evaluated;
		r.red_on = rx_red;
		r.blue_on = rx_blue;
		r.green_on = rx_green;
		r.receiving = rx_synced;
		return r;
	endfunction

	// ---------------------------------------------------------------- result side

	// The receiver stalls in runs of random length, when allowed to.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_now = stall_enable && ($urandom_range(2) == 0);
			stall_left = $urandom_range(1, 6);
		end else begin
			stall_left--;
		end
		result_stall <= stall_now;
	end

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Every accepted result is matched against the oldest decoded item still owed.
	always @(posedge clk) begin
		if (result_valid === 1'b1 && result_stall === 1'b0) begin
			if (pending_decodes.size() == 0) begin
				$error("result item arrived with no sample waiting for it");
				fail_count++;
			end else begin
				oldest_decode = pending_decodes.pop_front();
				check_field("decoded_value", oldest_decode.decoded_value, result.decoded_value);
				check_field("value_valid", 8'(oldest_decode.value_valid),
					8'(result.value_valid));
				check_field("red_on", 8'(oldest_decode.red_on), 8'(result.red_on));
				check_field("blue_on", 8'(oldest_decode.blue_on), 8'(result.blue_on));
				check_field("green_on", 8'(oldest_decode.green_on), 8'(result.green_on));
				check_field("receiving", 8'(oldest_decode.receiving), 8'(result.receiving));
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sample side

	// Sends one item and books its expected result once the block has taken it.
	// Items go out in bursts; between bursts the valid line drops while sender gaps are on.
	task automatic push_sample(input logic level, input logic tick_flag);
		in_item_t item;
		item.line_level = level;
		item.tick = tick_flag;
		if (burst_left == 0) begin
			if (sender_gaps) begin
				sample_valid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		sample_valid <= 1'b1;
		sample <= item;
		do @(posedge clk); while (sample_stall);
		pending_decodes.push_back(decode_sample(item));
		samples_sent++;
	endtask

	// One tick period: k samples at one level, the tick on the last of them.
	// A few samples may be inverted to exercise the majority vote.
	task automatic emit_period(input logic level, input int k, input int flip_pct);
		logic lv;
		for (int s = 0; s < k; s++) begin
			lv = level;
			if (flip_pct > 0 && $urandom_range(99) < flip_pct)
				lv = ~level;
			push_sample(lv, s == k - 1);
		end
	endtask

	// A high period followed by the sync low; the next sample sent is the rising edge.
	task automatic emit_sync(input int low_len, input int k);
		emit_period(1'b1, k, 0);
		repeat (low_len) emit_period(1'b0, k, 0);
	endtask

	// Slots from bit index top down to 0, each one pulse length long.
	task automatic emit_slots(input logic [13:0] slot_bits, input int top, input int k,
			input int flip_pct);
		for (int b = top; b >= 0; b--)
			repeat (int'(cfg_pulse)) emit_period(slot_bits[b], k, flip_pct);
	endtask

	task automatic emit_frame(input logic [7:0] value, input logic [3:0] chan,
			input int low_len, input logic [1:0] sync_bits, input int k, input int flip_pct);
		emit_sync(low_len, k);
		emit_slots({sync_bits, chan, value}, 13, k, flip_pct);
	endtask

	// Drops valid and waits for every result owed; the block is idle afterwards.
	task automatic await_all_results();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending_decodes.size() != 0);
	endtask

	// All three registers, one per clock, while nothing is in flight.
	task automatic set_registers(input logic [4:0] pulse, input logic [3:0] chan,
			input logic [7:0] timeout);
		await_all_results();
		cfg_write <= 1'b1;
		cfg_index <= CFG_PULSE_TICKS;
		cfg_data <= {3'b000, pulse};
		@(posedge clk);
		cfg_index <= CFG_CHANNEL_ID;
		cfg_data <= {4'b0000, chan};
		@(posedge clk);
		cfg_index <= CFG_TIMEOUT_TICKS;
		cfg_data <= timeout;
		@(posedge clk);
		cfg_write <= 1'b0;
		cfg_pulse = pulse;
		cfg_chan = chan;
		cfg_timeout = timeout;
	endtask

	// ---------------------------------------------------------------- tests

	// Random line activity while hunting: edges clear the tick counter, nothing syncs.
	task automatic test_hunting_noise();
		push_sample(1'b0, 1'b0);
		push_sample(1'b1, 1'b1);
		push_sample(1'b0, 1'b1);
		repeat (21) push_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	// One clean frame with the registers as reset leaves them.
	task automatic test_default_frame();
		stall_enable = 1'b0;
		emit_frame(8'hA5, CHANNEL_ID_RESET, int'(PULSE_TICKS_RESET), SYNC_GOOD, 1, 0);
		stall_enable = 1'b1;
	endtask

	// Repeated values 0, 1 and 2 light each lamp in turn.
	task automatic test_lamp_values();
		logic [7:0] values [3];
		values = '{8'd0, 8'd1, 8'd2};
		set_registers(5'd2, 4'd0, 8'd255);
		foreach (values[v])
			repeat (3) emit_frame(values[v], 4'd0, 2, SYNC_GOOD, 1, 0);
	endtask

	// Broken sync bits, a foreign channel, sync lows at and past the tolerance,
	// a tied vote, noisy slots and three packets that never agree.
	task automatic test_frame_faults();
		set_registers(5'd2, 4'd15, 8'd255);
		emit_frame(8'h11, 4'd15, 2, 2'b00, 1, 0);
		emit_frame(8'h22, 4'd15, 2, 2'b11, 1, 0);
		emit_frame(8'h33, 4'd14, 2, SYNC_GOOD, 1, 0);
		emit_frame(8'h55, 4'd15, 4, SYNC_GOOD, 1, 0);
		emit_frame(8'h66, 4'd15, 1, SYNC_GOOD, 1, 0);
		emit_frame(8'h66, 4'd15, 3, SYNC_GOOD, 1, 0);
		// Equal high and low samples in the first slot: a tie counts as a zero.
		emit_sync(2, 1);
		repeat (2) begin
			push_sample(1'b1, 1'b0);
			push_sample(1'b0, 1'b1);
		end
		emit_frame(8'h3C, 4'd15, 2, SYNC_GOOD, 3, 15);
		emit_frame(8'hC3, 4'd15, 2, SYNC_GOOD, 2, 0);
		emit_frame(8'h5A, 4'd15, 2, SYNC_GOOD, 1, 0);
		emit_frame(8'hA5, 4'd15, 2, SYNC_GOOD, 1, 0);
	endtask

	// Forced evaluation: once with a timeout of 1, and once when a longer
	// pulse stretches the frame header past the timeout after two matching packets.
	task automatic test_timeout_evaluation();
		set_registers(5'd2, 4'd7, 8'd1);
		emit_frame(8'h42, 4'd7, 2, SYNC_GOOD, 1, 0);
		set_registers(5'd3, 4'd7, 8'd30);
		repeat (2) emit_frame(8'h01, 4'd7, 3, SYNC_GOOD, 1, 0);
		set_registers(5'd5, 4'd7, 8'd30);
		emit_frame(8'h99, 4'd7, 5, SYNC_GOOD, 1, 0);
	endtask

	// The longest pulse keeps the last slot boundary just inside the tick counter;
	// the sync low sits at the short end of the tolerance.
	task automatic test_slow_pulse();
		set_registers(5'd18, 4'd9, 8'd255);
		emit_frame(8'h81, 4'd9, 17, SYNC_GOOD, 1, 0);
	endtask

	// Phases of random registers. Most traffic is well-formed frames that repeat a
	// value three times; the rest is stray values, foreign channels, broken sync,
	// off-length sync lows and plain line noise.
	task automatic test_random_traffic();
		int         start_count;
		int         phase_end;
		int         pick;
		int         k;
		int         flip;
		int         repeats_left;
		logic [7:0] frame_value;
		logic [7:0] timeout;
		logic [3:0] chan;
		logic [1:0] bad_sync;
		start_count = samples_sent;
		repeats_left = 0;
		frame_value = '0;
		while (samples_sent - start_count < RANDOM_ITEMS) begin
			chan = 4'($urandom_range(15));
			case ($urandom_range(3))
				0: timeout = 8'd255;
				1: timeout = 8'($urandom_range(1, 12));
				default: timeout = 8'($urandom_range(25, 120));
			endcase
			set_registers(5'($urandom_range(2, 5)), chan, timeout);
			sender_gaps = ($urandom_range(3) != 0);
			stall_enable = ($urandom_range(3) != 0);
			phase_end = samples_sent + $urandom_range(60, 120);
			while (samples_sent < phase_end) begin
				if (repeats_left == 0) begin
					case ($urandom_range(4))
						0: frame_value = 8'd0;
						1: frame_value = 8'd1;
						2: frame_value = 8'd2;
						default: frame_value = 8'($urandom);
					endcase
					repeats_left = 3;
				end
				pick = $urandom_range(99);
				k = ($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1;
				flip = (k > 1) ? $urandom_range(12) : 0;
				if (pick < 60) begin
					emit_frame(frame_value, chan, int'(cfg_pulse), SYNC_GOOD, k, flip);
					repeats_left--;
				end else if (pick < 66) begin
					emit_frame(8'($urandom), chan, int'(cfg_pulse) + $urandom_range(2) - 1,
						SYNC_GOOD, k, flip);
				end else if (pick < 74) begin
					emit_frame(frame_value, chan ^ 4'($urandom_range(1, 15)), int'(cfg_pulse),
						SYNC_GOOD, k, flip);
				end else if (pick < 80) begin
					bad_sync = 2'($urandom_range(2));
					if (bad_sync == SYNC_GOOD)
						bad_sync = 2'b11;
					emit_frame(frame_value, chan, int'(cfg_pulse), bad_sync, k, flip);
				end else if (pick < 88) begin
					emit_frame(frame_value, chan,
						int'(cfg_pulse) + (($urandom_range(1) != 0) ? 2 : -2), SYNC_GOOD, k, flip);
				end else begin
					repeat ($urandom_range(3, 15))
						push_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
				end
			end
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		rx_reset_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_hunting_noise();
		test_default_frame();
		test_lamp_values();
		test_frame_faults();
		test_timeout_evaluation();
		test_slow_pulse();
		test_random_traffic();
		await_all_results();
		// A short tail catches any result the block sends beyond those owed.
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
